// File: rtl/rti_pkg.sv
// rti_pkg: shared constants for the ray/triangle intersection block.
// Holds the configuration register map. No dependencies.
package rti_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX0 = 2'd0,
        REG_VERTEX1 = 2'd1,
        REG_VERTEX2 = 2'd2
    } cfg_reg_t;

    localparam int NUM_LANES = 3;

endpackage

// File: rtl/ray_triangle_intersect.sv
// ray_triangle_intersect: pipelined fixed-point Moller-Trumbore ray/triangle unit.
// Uses rti_pkg (register map). Arithmetic, pipeline and dividers all in this file.
//
// channel   direction  handshake           payload
// config    in         cfg_we              cfg_index, cfg_wdata (one packed vertex)
// ray       in         start && !busy      origin_x/y/z, dir_x/y/z
// result    out        done (one cycle)    hit_distance, bary_one, bary_two, degenerate
//
// One ray per cycle; busy is never raised.
// The pipeline has five arithmetic stages, one divider set-up stage,
// OUT_WIDTH restoring divider stages (one quotient bit each) and the output register.
// Reset clears the vertices and all valid bits; rays in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = 16,
    parameter int OUT_WIDTH   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [3*COORD_WIDTH-1:0]          cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_WIDTH-1:0]     origin_x,
    input  logic signed [COORD_WIDTH-1:0]     origin_y,
    input  logic signed [COORD_WIDTH-1:0]     origin_z,
    input  logic signed [COORD_WIDTH-1:0]     dir_x,
    input  logic signed [COORD_WIDTH-1:0]     dir_y,
    input  logic signed [COORD_WIDTH-1:0]     dir_z,
    output logic                              done,
    output logic signed [OUT_WIDTH-1:0]       hit_distance,
    output logic signed [OUT_WIDTH-1:0]       bary_one,
    output logic signed [OUT_WIDTH-1:0]       bary_two,
    output logic                              degenerate
);

    localparam int CW  = COORD_WIDTH;
    localparam int OW  = OUT_WIDTH;
    localparam int NL  = rti_pkg::NUM_LANES;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int XW  = PW + 1;
    localparam int YW  = XW + DW;
    localparam int NWF = YW + 2;
    localparam int LW  = (NWF > 64) ? 64 : NWF;
    localparam int OF  = OW / 2;
    localparam int SH  = OW - OF;
    localparam int RW  = LW + 1;
    localparam int EW  = LW + OW;

    localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] NEG_MAG = {1'b1, {(OW-1){1'b0}}};

    // configuration
    logic [3*CW-1:0] vertex_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_reg[0] <= '0;
            vertex_reg[1] <= '0;
            vertex_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rti_pkg::REG_VERTEX0: vertex_reg[0] <= cfg_wdata;
                rti_pkg::REG_VERTEX1: vertex_reg[1] <= cfg_wdata;
                rti_pkg::REG_VERTEX2: vertex_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [DW-1:0] v0c [0:2];
    logic signed [DW-1:0] e1  [0:2];
    logic signed [DW-1:0] e2  [0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            v0c[k] = DW'($signed(vertex_reg[0][k*CW +: CW]));
            e1[k]  = DW'($signed(vertex_reg[1][k*CW +: CW])) - v0c[k];
            e2[k]  = DW'($signed(vertex_reg[2][k*CW +: CW])) - v0c[k];
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    logic [4:0] vld_reg;

    // stage 1: s = o - v0, d
    logic signed [DW-1:0] s_reg [0:2];
    logic signed [DW-1:0] d_reg [0:2];

    always_ff @(posedge clk)
    begin
        s_reg[0] <= DW'(origin_x) - v0c[0];
        s_reg[1] <= DW'(origin_y) - v0c[1];
        s_reg[2] <= DW'(origin_z) - v0c[2];
        d_reg[0] <= DW'(dir_x);
        d_reg[1] <= DW'(dir_y);
        d_reg[2] <= DW'(dir_z);
    end

    // stage 2: cross product partial products
    logic signed [PW-1:0] pa_reg [0:5];
    logic signed [PW-1:0] pb_reg [0:5];
    logic signed [DW-1:0] s2_reg [0:2];
    logic signed [DW-1:0] d2_reg [0:2];

    always_ff @(posedge clk)
    begin
        pa_reg[0] <= d_reg[1] * e2[2];
        pa_reg[1] <= d_reg[2] * e2[1];
        pa_reg[2] <= d_reg[2] * e2[0];
        pa_reg[3] <= d_reg[0] * e2[2];
        pa_reg[4] <= d_reg[0] * e2[1];
        pa_reg[5] <= d_reg[1] * e2[0];
        pb_reg[0] <= s_reg[1] * e1[2];
        pb_reg[1] <= s_reg[2] * e1[1];
        pb_reg[2] <= s_reg[2] * e1[0];
        pb_reg[3] <= s_reg[0] * e1[2];
        pb_reg[4] <= s_reg[0] * e1[1];
        pb_reg[5] <= s_reg[1] * e1[0];
        s2_reg    <= s_reg;
        d2_reg    <= d_reg;
    end

    // stage 3: s1 = d x e2, s2 = s x e1
    logic signed [XW-1:0] c1_reg [0:2];
    logic signed [XW-1:0] c2_reg [0:2];
    logic signed [DW-1:0] s3_reg [0:2];
    logic signed [DW-1:0] d3_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            c1_reg[k] <= XW'(pa_reg[2*k]) - XW'(pa_reg[2*k+1]);
            c2_reg[k] <= XW'(pb_reg[2*k]) - XW'(pb_reg[2*k+1]);
        end
        s3_reg <= s2_reg;
        d3_reg <= d2_reg;
    end

    // stage 4: dot product terms
    logic signed [YW-1:0] tp_reg  [0:2];
    logic signed [YW-1:0] b1p_reg [0:2];
    logic signed [YW-1:0] b2p_reg [0:2];
    logic signed [YW-1:0] qp_reg  [0:2];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            tp_reg[k]  <= c2_reg[k] * e2[k];
            b1p_reg[k] <= c1_reg[k] * s3_reg[k];
            b2p_reg[k] <= c2_reg[k] * d3_reg[k];
            qp_reg[k]  <= c1_reg[k] * e1[k];
        end
    end

    // stage 5: numerators and biased determinant
    logic signed [LW-1:0] num_reg [0:NL-1];
    logic signed [LW-1:0] q_reg;
    logic signed [NWF-1:0] q_full;

    assign q_full = NWF'(qp_reg[0]) + NWF'(qp_reg[1]) + NWF'(qp_reg[2]) + NWF'(1);

    always_ff @(posedge clk)
    begin
        num_reg[0] <= LW'(NWF'(tp_reg[0]) + NWF'(tp_reg[1]) + NWF'(tp_reg[2]));
        num_reg[1] <= LW'(NWF'(b1p_reg[0]) + NWF'(b1p_reg[1]) + NWF'(b1p_reg[2]));
        num_reg[2] <= LW'(NWF'(b2p_reg[0]) + NWF'(b2p_reg[1]) + NWF'(b2p_reg[2]));
        q_reg      <= LW'(q_full);
    end

    // divider set-up: magnitudes, overflow test, initial remainder
    logic [LW-1:0] ad_prep;
    logic          deg_prep;
    logic [LW-1:0] rem_prep [0:NL-1];
    logic [OW-1:0] lo_prep  [0:NL-1];
    logic          ovf_prep [0:NL-1];
    logic          neg_prep [0:NL-1];

    always_comb
    begin
        logic [LW-1:0] an;
        logic [EW-1:0] an_ext;
        logic [EW-1:0] top;
        ad_prep  = q_reg[LW-1] ? LW'(-q_reg) : LW'(q_reg);
        deg_prep = (q_reg == '0);
        for (int l = 0; l < NL; l++)
        begin
            an          = num_reg[l][LW-1] ? LW'(-num_reg[l]) : LW'(num_reg[l]);
            an_ext      = EW'(an);
            top         = an_ext >> SH;
            lo_prep[l]  = OW'(an_ext << OF);
            ovf_prep[l] = (top >= EW'(ad_prep));
            rem_prep[l] = LW'(top);
            neg_prep[l] = num_reg[l][LW-1] ^ q_reg[LW-1];
        end
    end

    // restoring divider stages, one quotient bit per stage
    logic [LW-1:0] rem_reg [0:OW][0:NL-1];
    logic [OW-1:0] lo_reg  [0:OW][0:NL-1];
    logic [OW-1:0] quo_reg [0:OW][0:NL-1];
    logic          ovf_reg [0:OW][0:NL-1];
    logic          neg_reg [0:OW][0:NL-1];
    logic [LW-1:0] ad_reg  [0:OW];
    logic          deg_reg [0:OW];
    logic [OW:0]   dvld_reg;

    logic [RW-1:0] trial   [0:OW-1][0:NL-1];
    logic          take    [0:OW-1][0:NL-1];

    always_comb
    begin
        for (int k = 0; k < OW; k++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                trial[k][l] = {rem_reg[k][l], lo_reg[k][l][OW-1]};
                take[k][l]  = (trial[k][l] >= RW'(ad_reg[k]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ad_reg[0]  <= ad_prep;
        deg_reg[0] <= deg_prep;
        for (int l = 0; l < NL; l++)
        begin
            rem_reg[0][l] <= rem_prep[l];
            lo_reg[0][l]  <= lo_prep[l];
            quo_reg[0][l] <= '0;
            ovf_reg[0][l] <= ovf_prep[l];
            neg_reg[0][l] <= neg_prep[l];
        end
        for (int k = 0; k < OW; k++)
        begin
            ad_reg[k+1]  <= ad_reg[k];
            deg_reg[k+1] <= deg_reg[k];
            for (int l = 0; l < NL; l++)
            begin
                rem_reg[k+1][l] <= take[k][l] ? LW'(trial[k][l] - RW'(ad_reg[k]))
                                               : LW'(trial[k][l]);
                lo_reg[k+1][l]  <= lo_reg[k][l] << 1;
                quo_reg[k+1][l] <= {quo_reg[k][l][OW-2:0], take[k][l]};
                ovf_reg[k+1][l] <= ovf_reg[k][l];
                neg_reg[k+1][l] <= neg_reg[k][l];
            end
        end
    end

    // saturate and apply sign
    logic [OW-1:0] res_next [0:NL-1];

    always_comb
    begin
        logic [OW-1:0] lim;
        logic [OW-1:0] mag;
        for (int l = 0; l < NL; l++)
        begin
            lim = neg_reg[OW][l] ? NEG_MAG : POS_MAX;
            mag = (ovf_reg[OW][l] || (quo_reg[OW][l] > lim)) ? lim : quo_reg[OW][l];
            res_next[l] = neg_reg[OW][l] ? (~mag + OW'(1)) : mag;
        end
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            dvld_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[3:0], accept};
            dvld_reg <= {dvld_reg[OW-1:0], vld_reg[4]};
            done_reg <= dvld_reg[OW];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_distance <= res_next[0];
        bary_one     <= res_next[1];
        bary_two     <= res_next[2];
        degenerate   <= deg_reg[OW];
    end

    assign done = done_reg;

    // zero biased determinant (the divisor) always lands on the saturated extremes
    a_deg_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |->
            (hit_distance == POS_MAX || hit_distance == NEG_MAG) &&
            (bary_one == POS_MAX || bary_one == NEG_MAG) &&
            (bary_two == POS_MAX || bary_two == NEG_MAG))
        else $error("degenerate result not saturated");

    // a zero divisor must be caught by the overflow test
    a_deg_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        dvld_reg[0] && deg_reg[0] |->
            ovf_reg[0][0] && ovf_reg[0][1] && ovf_reg[0][2])
        else $error("zero divisor without overflow");

    // partial remainder stays below the divisor once the quotient fits
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dvld_reg[OW] |->
            (ovf_reg[OW][0] || rem_reg[OW][0] < ad_reg[OW]) &&
            (ovf_reg[OW][1] || rem_reg[OW][1] < ad_reg[OW]) &&
            (ovf_reg[OW][2] || rem_reg[OW][2] < ad_reg[OW]))
        else $error("divider remainder out of range");

endmodule
